@@ rtl/trs_pkg.sv @@
// shared types and constants of the trapezoid ramp speed block
package trs_pkg;

  localparam int unsigned SCALE_ONE     = 65536;
  localparam int unsigned SCALE_MIN_MAG = 131072;
  localparam int unsigned DRIVE_MAX     = 2047;
  localparam int unsigned QM_BITS       = 18;
  localparam int unsigned QR_BITS       = 11;

  typedef enum logic [2:0] {
    CFG_START  = 3'd0,
    CFG_CRUISE = 3'd1,
    CFG_END    = 3'd2,
    CFG_UP     = 3'd3,
    CFG_DOWN   = 3'd4
  } cfg_index_t;

  // front stage: magnitudes and band ranges
  typedef struct packed {
    logic [24:0]        p;
    logic [24:0]        l;
    logic               neg;
    logic               zero;
    logic [9:0]         st;
    logic [9:0]         mid;
    logic [9:0]         en;
    logic [15:0]        us;
    logic [15:0]        ds;
    logic signed [27:0] ur;
    logic signed [27:0] dr;
  } trs_front_t;

  // state carried along the division chain
  typedef struct packed {
    logic [24:0]        p;
    logic [24:0]        l;
    logic               neg;
    logic               zero;
    logic [9:0]         st;
    logic [9:0]         mid;
    logic [9:0]         en;
    logic signed [27:0] ur;
    logic signed [27:0] dr;
    logic               sum_neg;
    logic               sum_zero;
    logic               m_ovf;
    logic [27:0]        dm;
    logic [41:0]        rem_m;
    logic [17:0]        q_m;
    logic               up_ovf;
    logic [16:0]        dup;
    logic [25:0]        rem_up;
    logic [10:0]        q_up;
    logic               dn_ovf;
    logic [16:0]        ddn;
    logic [25:0]        rem_dn;
    logic [10:0]        q_dn;
  } trs_work_t;

  // back stage: band products and candidate speeds
  typedef struct packed {
    logic [24:0]        p;
    logic               neg;
    logic               zero;
    logic               st_ne;
    logic               en_ne;
    logic [9:0]         mid;
    logic signed [47:0] prod_up;
    logic signed [47:0] prod_dn;
    logic [10:0]        up_sp;
    logic [10:0]        dn_sp;
  } trs_back_t;

endpackage

@@ rtl/trs_if.sv @@
// valid/ready channel interfaces for input and result transactions
interface trs_in_if (input logic clk);
  logic               valid;
  logic               ready;
  logic signed [24:0] progress;
  logic signed [24:0] move_length;
  modport source (output valid, output progress, output move_length, input ready);
  modport sink (input valid, input progress, input move_length, output ready);
endinterface

interface trs_out_if (input logic clk);
  logic               valid;
  logic               ready;
  logic signed [11:0] drive;
  modport source (output valid, output drive, input ready);
  modport sink (input valid, input drive, output ready);
endinterface

@@ rtl/trapezoid_ramp_speed.sv @@
// top level: trapezoidal speed profile from progress and move length
// One transaction per cycle in steady state while the output accepts results;
// a result passes two front stages, a chain of 18 restoring-division cells
// that computes the band scale and both ramp quotients side by side, and two
// back stages for the band products and the final selection. Every stage has
// its own valid bit, so empty stages fill while a result waits at the output.
// Configuration registers are written through cfg_write/cfg_index/cfg_data by the user
// while no transaction is in flight, not enforced by the block; indexes above 4 are ignored.
module trapezoid_ramp_speed (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  trs_in_if.sink      din,
  trs_out_if.source   dout
);

  localparam int unsigned NCELL = trs_pkg::QM_BITS;

  logic [9:0]  start_speed;
  logic [9:0]  cruise_speed;
  logic [9:0]  end_speed;
  logic [15:0] up_slope;
  logic [15:0] down_slope;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_speed <= '0;
      cruise_speed <= '0;
      end_speed <= '0;
      up_slope <= 16'd256;
      down_slope <= 16'd256;
    end else if (cfg_write) begin
      case (trs_pkg::cfg_index_t'(cfg_index))
        trs_pkg::CFG_START:  start_speed <= cfg_data[9:0];
        trs_pkg::CFG_CRUISE: cruise_speed <= cfg_data[9:0];
        trs_pkg::CFG_END:    end_speed <= cfg_data[9:0];
        trs_pkg::CFG_UP:     up_slope <= cfg_data;
        trs_pkg::CFG_DOWN:   down_slope <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage a: magnitudes, slopes, band ranges
  logic                va;
  logic                rdy_a;
  trs_pkg::trs_front_t fa;
  trs_pkg::trs_front_t fa_next;
  logic signed [10:0]  dsu;
  logic signed [10:0]  dsd;

  // stage b: numerators, divisors, overflow checks
  logic                vb;
  logic                rdy_b;
  trs_pkg::trs_work_t  wb;
  trs_pkg::trs_work_t  wb_next;
  logic signed [27:0]  sum;
  logic [26:0]         abs_s;
  logic signed [25:0]  diff;

  logic [NCELL:0]      cv;
  logic [NCELL:0]      cr;
  trs_pkg::trs_work_t  cw [NCELL+1];

  // stage c: scale, products, candidate speeds
  logic                vc;
  logic                rdy_c;
  trs_pkg::trs_back_t  bc;
  trs_pkg::trs_back_t  bc_next;
  logic signed [18:0]  m;
  logic signed [28:0]  ldr;
  logic [11:0]         up_sum;
  logic [11:0]         dn_sum;
  trs_pkg::trs_work_t  wt;

  // stage d: output register
  logic                vd;
  logic                rdy_d;
  logic signed [11:0]  drive_r;
  logic signed [11:0]  drive_next;
  logic                zero_r;
  logic signed [47:0]  pscaled;
  logic [10:0]         speed;

  assign rdy_d = !vd || dout.ready;
  assign rdy_c = !vc || rdy_d;
  assign rdy_b = !vb || cr[0];
  assign rdy_a = !va || rdy_b;
  assign din.ready = rdy_a;

  always_comb begin
    fa_next.p = din.progress[24] ? 25'(~din.progress + 25'sd1) : din.progress;
    fa_next.l = din.move_length[24] ? 25'(~din.move_length + 25'sd1) : din.move_length;
    fa_next.neg = din.move_length[24];
    fa_next.zero = (din.move_length == '0);
    fa_next.st = start_speed;
    fa_next.mid = cruise_speed;
    fa_next.en = end_speed;
    // a zero slope acts as one
    fa_next.us = (up_slope == '0) ? 16'd1 : up_slope;
    fa_next.ds = (down_slope == '0) ? 16'd1 : down_slope;
    dsu = $signed({1'b0, cruise_speed}) - $signed({1'b0, start_speed});
    dsd = $signed({1'b0, cruise_speed}) - $signed({1'b0, end_speed});
    fa_next.ur = 28'(dsu) * $signed({12'd0, fa_next.us});
    fa_next.dr = 28'(dsd) * $signed({12'd0, fa_next.ds});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (rdy_a) begin
      va <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && din.valid) begin
      fa <= fa_next;
    end
  end

  always_comb begin
    sum = fa.ur + fa.dr;
    abs_s = sum[27] ? 27'(-sum) : 27'(sum);
    diff = $signed({1'b0, fa.l}) - $signed({1'b0, fa.p});
    wb_next.p = fa.p;
    wb_next.l = fa.l;
    wb_next.neg = fa.neg;
    wb_next.zero = fa.zero;
    wb_next.st = fa.st;
    wb_next.mid = fa.mid;
    wb_next.en = fa.en;
    wb_next.ur = fa.ur;
    wb_next.dr = fa.dr;
    wb_next.sum_neg = sum[27];
    wb_next.sum_zero = (sum == '0);
    // round half away: (2n + d) / (2d)
    wb_next.dm = {abs_s, 1'b0};
    wb_next.rem_m = {fa.l, 17'd0} + 42'(abs_s);
    wb_next.m_ovf = 46'(wb_next.rem_m) >= {wb_next.dm, 18'd0};
    wb_next.q_m = '0;
    wb_next.dup = {fa.us, 1'b0};
    wb_next.rem_up = {fa.p, 1'b0} + 26'(fa.us);
    wb_next.up_ovf = 28'(wb_next.rem_up) >= {wb_next.dup, 11'd0};
    wb_next.q_up = '0;
    wb_next.ddn = {fa.ds, 1'b0};
    wb_next.rem_dn = (diff > 26'sd0) ? ({diff[24:0], 1'b0} + 26'(fa.ds)) : 26'd0;
    wb_next.dn_ovf = 28'(wb_next.rem_dn) >= {wb_next.ddn, 11'd0};
    wb_next.q_dn = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (rdy_b) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b && va) begin
      wb <= wb_next;
    end
  end

  assign cv[0] = vb;
  assign cw[0] = wb;
  assign cr[NCELL] = rdy_c;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    trs_div_cell #(
      .IDX(NCELL - 1 - k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (cv[k]),
      .in_ready (cr[k]),
      .in_work  (cw[k]),
      .out_valid(cv[k+1]),
      .out_ready(cr[k+1]),
      .out_work (cw[k+1])
    );
  end

  assign wt = cw[NCELL];

  always_comb begin
    if (wt.sum_zero) begin
      m = 19'sd65536;
    end else if (!wt.sum_neg) begin
      m = (wt.m_ovf || 32'(wt.q_m) > trs_pkg::SCALE_ONE) ? 19'sd65536 : $signed(19'(wt.q_m));
    end else begin
      m = (wt.m_ovf || 32'(wt.q_m) > trs_pkg::SCALE_MIN_MAG) ? -19'sd131072
                                                             : -$signed(19'(wt.q_m));
    end
    ldr = $signed({4'd0, wt.l}) - 29'(wt.dr);
    up_sum = 12'(wt.q_up) + 12'(wt.st);
    dn_sum = 12'(wt.q_dn) + 12'(wt.en);
    bc_next.p = wt.p;
    bc_next.neg = wt.neg;
    bc_next.zero = wt.zero;
    bc_next.st_ne = (wt.st != wt.mid);
    bc_next.en_ne = (wt.en != wt.mid);
    bc_next.mid = wt.mid;
    bc_next.prod_up = 48'(wt.ur) * 48'(m);
    bc_next.prod_dn = 48'(ldr) * 48'(m);
    bc_next.up_sp = (wt.up_ovf || 32'(up_sum) > trs_pkg::DRIVE_MAX) ? 11'(trs_pkg::DRIVE_MAX)
                                                                   : up_sum[10:0];
    bc_next.dn_sp = (wt.dn_ovf || 32'(dn_sum) > trs_pkg::DRIVE_MAX) ? 11'(trs_pkg::DRIVE_MAX)
                                                                   : dn_sum[10:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (rdy_c) begin
      vc <= cv[NCELL];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c && cv[NCELL]) begin
      bc <= bc_next;
    end
  end

  always_comb begin
    pscaled = $signed({7'd0, bc.p, 16'd0});
    if (bc.st_ne && pscaled < bc.prod_up) begin
      speed = bc.up_sp;
    end else if (bc.en_ne && pscaled > bc.prod_dn) begin
      speed = bc.dn_sp;
    end else begin
      speed = {1'b0, bc.mid};
    end
    if (bc.zero) begin
      drive_next = '0;
    end else if (bc.neg) begin
      drive_next = -$signed({1'b0, speed});
    end else begin
      drive_next = $signed({1'b0, speed});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (rdy_d) begin
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_d && vc) begin
      drive_r <= drive_next;
      zero_r <= bc.zero;
    end
  end

  assign dout.valid = vd;
  assign dout.drive = drive_r;

  a_scale_range: assert property (@(posedge clk) disable iff (rst)
    cv[NCELL] |-> (m <= 19'sd65536 && m >= -19'sd131072))
    else $error("band scale out of range");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    vd |-> (drive_r != -12'sd2048))
    else $error("drive outside saturation range");

  a_zero_move: assert property (@(posedge clk) disable iff (rst)
    (vd && zero_r) |-> (drive_r == 12'sd0))
    else $error("zero move length gave nonzero drive");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!vd && !vc && !va && !vb))
    else $error("pipeline not empty after reset");

endmodule

@@ rtl/trs_div_cell.sv @@
// one restoring division step for the scale and, in the low cells, both ramp quotients
module trs_div_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  trs_pkg::trs_work_t in_work,
  output logic              out_valid,
  input  logic              out_ready,
  output trs_pkg::trs_work_t out_work
);

  trs_pkg::trs_work_t work_next;
  logic [45:0]        dm_sh;
  logic [27:0]        dup_sh;
  logic [27:0]        ddn_sh;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    work_next = in_work;
    dm_sh = 46'(in_work.dm) << IDX;
    dup_sh = 28'(in_work.dup) << IDX;
    ddn_sh = 28'(in_work.ddn) << IDX;
    if (46'(in_work.rem_m) >= dm_sh) begin
      work_next.rem_m = in_work.rem_m - dm_sh[41:0];
      work_next.q_m[IDX] = 1'b1;
    end
    // ramp quotients only need the low bits
    if (IDX < trs_pkg::QR_BITS) begin
      if (28'(in_work.rem_up) >= dup_sh) begin
        work_next.rem_up = in_work.rem_up - dup_sh[25:0];
        work_next.q_up[IDX % trs_pkg::QR_BITS] = 1'b1;
      end
      if (28'(in_work.rem_dn) >= ddn_sh) begin
        work_next.rem_dn = in_work.rem_dn - ddn_sh[25:0];
        work_next.q_dn[IDX % trs_pkg::QR_BITS] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_work <= work_next;
    end
  end

endmodule
